// File: rtl/core/hgide_pkg.sv
// Package for the HID global item delta encoder.
// Holds the sequencer types, the item tags and the control program table.
// Depends on nothing; imported by hid_global_item_delta_encoder.
package hgide_pkg;

    localparam int STEP_COUNT = 10;
    localparam int STEP_W     = 4;

    localparam logic [7:0] TAG_USAGE_PAGE   = 8'h04;
    localparam logic [7:0] TAG_LOG_MIN      = 8'h14;
    localparam logic [7:0] TAG_LOG_MAX      = 8'h24;
    localparam logic [7:0] TAG_PHY_MIN      = 8'h34;
    localparam logic [7:0] TAG_PHY_MAX      = 8'h44;
    localparam logic [7:0] TAG_UNIT_EXP     = 8'h54;
    localparam logic [7:0] TAG_UNIT         = 8'h64;
    localparam logic [7:0] TAG_REPORT_SIZE  = 8'h74;
    localparam logic [7:0] TAG_REPORT_ID    = 8'h84;
    localparam logic [7:0] TAG_REPORT_COUNT = 8'h94;
    localparam logic [7:0] TAG_MASK         = 8'hFC;
    localparam logic [7:0] NO_ID_YET        = 8'hFF;

    localparam logic FUNC_EMIT     = 1'b0;
    localparam logic FUNC_SET_PAGE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN
    } state_t;

    typedef enum logic [1:0] {
        KIND_ID,
        KIND_PAGE,
        KIND_SIGNED,
        KIND_UNSIGNED
    } kind_t;

    typedef enum logic [3:0] {
        FLD_REPORT_ID,
        FLD_USAGE_PAGE,
        FLD_LOGICAL_MIN,
        FLD_LOGICAL_MAX,
        FLD_PHYSICAL_MIN,
        FLD_PHYSICAL_MAX,
        FLD_UNIT_EXPONENT,
        FLD_UNIT_CODE,
        FLD_FIELD_SIZE,
        FLD_FIELD_COUNT
    } field_t;

    typedef struct packed {
        field_t     field;
        kind_t      kind;
        logic [7:0] tag;
        logic       end_step;
    } ctrl_word_t;

    // One control word per field, in the order the items are sent.
    function automatic ctrl_word_t ctrl_rom(input logic [STEP_W-1:0] step);
        ctrl_word_t w;
        w = '{FLD_REPORT_ID, KIND_ID, TAG_REPORT_ID, 1'b0};
        case (step)
            4'd0: w = '{FLD_REPORT_ID,     KIND_ID,       TAG_REPORT_ID,    1'b0};
            4'd1: w = '{FLD_USAGE_PAGE,    KIND_PAGE,     TAG_USAGE_PAGE,   1'b0};
            4'd2: w = '{FLD_LOGICAL_MIN,   KIND_SIGNED,   TAG_LOG_MIN,      1'b0};
            4'd3: w = '{FLD_LOGICAL_MAX,   KIND_SIGNED,   TAG_LOG_MAX,      1'b0};
            4'd4: w = '{FLD_PHYSICAL_MIN,  KIND_SIGNED,   TAG_PHY_MIN,      1'b0};
            4'd5: w = '{FLD_PHYSICAL_MAX,  KIND_SIGNED,   TAG_PHY_MAX,      1'b0};
            4'd6: w = '{FLD_UNIT_EXPONENT, KIND_UNSIGNED, TAG_UNIT_EXP,     1'b0};
            4'd7: w = '{FLD_UNIT_CODE,     KIND_UNSIGNED, TAG_UNIT,         1'b0};
            4'd8: w = '{FLD_FIELD_SIZE,    KIND_UNSIGNED, TAG_REPORT_SIZE,  1'b0};
            4'd9: w = '{FLD_FIELD_COUNT,   KIND_UNSIGNED, TAG_REPORT_COUNT, 1'b1};
            default: w = '{FLD_FIELD_COUNT, KIND_UNSIGNED, TAG_REPORT_COUNT, 1'b1};
        endcase
        return w;
    endfunction

endpackage

// File: rtl/core/hid_global_item_delta_encoder.sv
// HID global item delta encoder: compares a set of global values with the last one
// sent and emits short items for the fields that differ. Uses hgide_pkg.
// The first output byte is registered in ST_RUN, after the input transfer moves to ST_RUN.
// The input is not taken again until the item is through: s_tready stays low in ST_RUN
// while the ten-step control program sends each output byte and steps over each unchanged
// field ahead of the last changed one, and while the output is held. An item that changes
// nothing, or a usage page overwrite, stays in ST_IDLE. Reset loads report id 255.
module hid_global_item_delta_encoder (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // report_id, usage_page, logical_min, logical_max, physical_min, physical_max,
    // unit_exponent, unit_code, field_size, field_count
    input  logic [247:0] s_tdata,
    // func
    input  logic         s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_byte
    output logic [7:0]   m_tdata,
    output logic         m_tlast
);
    import hgide_pkg::*;

    state_t                  state_reg, state_next;
    logic [STEP_W-1:0]       step_reg, step_next;
    logic [2:0]              byte_reg, byte_next;
    logic [STEP_COUNT-1:0]   change_reg, change_next;
    logic                    m_tvalid_reg, m_tvalid_next;
    logic [7:0]              m_tdata_reg, m_tdata_next;
    logic                    m_tlast_reg, m_tlast_next;

    logic [7:0]  prev_report_id_reg;
    logic [15:0] prev_usage_page_reg;
    logic [31:0] prev_logical_min_reg;
    logic [31:0] prev_logical_max_reg;
    logic [31:0] prev_physical_min_reg;
    logic [31:0] prev_physical_max_reg;
    logic [31:0] prev_unit_exponent_reg;
    logic [31:0] prev_unit_code_reg;
    logic [15:0] prev_field_size_reg;
    logic [15:0] prev_field_count_reg;

    logic [7:0]  in_report_id;
    logic [15:0] in_usage_page;
    logic [31:0] in_logical_min;
    logic [31:0] in_logical_max;
    logic [31:0] in_physical_min;
    logic [31:0] in_physical_max;
    logic [31:0] in_unit_exponent;
    logic [31:0] in_unit_code;
    logic [15:0] in_field_size;
    logic [15:0] in_field_count;

    logic                  in_xfer;
    logic [STEP_COUNT-1:0] in_change;
    ctrl_word_t            ctrl;
    logic [31:0]           sel_value;
    logic [1:0]            size_code;
    logic [2:0]            nbytes;
    logic [STEP_COUNT-1:0] later_mask;
    logic                  out_free;

    assign in_report_id     = s_tdata[7:0];
    assign in_usage_page    = s_tdata[23:8];
    assign in_logical_min   = s_tdata[55:24];
    assign in_logical_max   = s_tdata[87:56];
    assign in_physical_min  = s_tdata[119:88];
    assign in_physical_max  = s_tdata[151:120];
    assign in_unit_exponent = s_tdata[183:152];
    assign in_unit_code     = s_tdata[215:184];
    assign in_field_size    = s_tdata[231:216];
    assign in_field_count   = s_tdata[247:232];

    assign s_tready = (state_reg == ST_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    assign in_change = {
        in_field_count   != prev_field_count_reg,
        in_field_size    != prev_field_size_reg,
        in_unit_code     != prev_unit_code_reg,
        in_unit_exponent != prev_unit_exponent_reg,
        in_physical_max  != prev_physical_max_reg,
        in_physical_min  != prev_physical_min_reg,
        in_logical_max   != prev_logical_max_reg,
        in_logical_min   != prev_logical_min_reg,
        in_usage_page    != prev_usage_page_reg,
        in_report_id     != prev_report_id_reg
    };

    // Emit loads the stored set, a page overwrite only the page; the program reads it back.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_report_id_reg     <= NO_ID_YET;
            prev_usage_page_reg    <= '0;
            prev_logical_min_reg   <= '0;
            prev_logical_max_reg   <= '0;
            prev_physical_min_reg  <= '0;
            prev_physical_max_reg  <= '0;
            prev_unit_exponent_reg <= '0;
            prev_unit_code_reg     <= '0;
            prev_field_size_reg    <= '0;
            prev_field_count_reg   <= '0;
        end else if (in_xfer) begin
            prev_usage_page_reg <= in_usage_page;
            if (s_tuser == FUNC_EMIT) begin
                prev_report_id_reg     <= in_report_id;
                prev_logical_min_reg   <= in_logical_min;
                prev_logical_max_reg   <= in_logical_max;
                prev_physical_min_reg  <= in_physical_min;
                prev_physical_max_reg  <= in_physical_max;
                prev_unit_exponent_reg <= in_unit_exponent;
                prev_unit_code_reg     <= in_unit_code;
                prev_field_size_reg    <= in_field_size;
                prev_field_count_reg   <= in_field_count;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            step_reg     <= '0;
            byte_reg     <= '0;
            change_reg   <= '0;
            m_tvalid_reg <= 1'b0;
            m_tlast_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            byte_reg     <= byte_next;
            change_reg   <= change_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tlast_reg  <= m_tlast_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    always_comb begin
        ctrl = ctrl_rom(step_reg);
        case (ctrl.field)
            FLD_REPORT_ID:     sel_value = {24'd0, prev_report_id_reg};
            FLD_USAGE_PAGE:    sel_value = {16'd0, prev_usage_page_reg};
            FLD_LOGICAL_MIN:   sel_value = prev_logical_min_reg;
            FLD_LOGICAL_MAX:   sel_value = prev_logical_max_reg;
            FLD_PHYSICAL_MIN:  sel_value = prev_physical_min_reg;
            FLD_PHYSICAL_MAX:  sel_value = prev_physical_max_reg;
            FLD_UNIT_EXPONENT: sel_value = prev_unit_exponent_reg;
            FLD_UNIT_CODE:     sel_value = prev_unit_code_reg;
            FLD_FIELD_SIZE:    sel_value = {16'd0, prev_field_size_reg};
            FLD_FIELD_COUNT:   sel_value = {16'd0, prev_field_count_reg};
            default:           sel_value = '0;
        endcase

        case (ctrl.kind)
            KIND_ID: size_code = 2'd1;
            KIND_PAGE: size_code = (sel_value[15:8] != 8'd0) ? 2'd2 : 2'd1;
            KIND_SIGNED: begin
                if (sel_value == 32'd0) begin
                    size_code = 2'd0;
                end else if ((&sel_value[31:7]) || !(|sel_value[31:7])) begin
                    size_code = 2'd1;
                end else if ((&sel_value[31:15]) || !(|sel_value[31:15])) begin
                    size_code = 2'd2;
                end else begin
                    size_code = 2'd3;
                end
            end
            KIND_UNSIGNED: begin
                if (sel_value == 32'd0) begin
                    size_code = 2'd0;
                end else if (sel_value[31:8] == 24'd0) begin
                    size_code = 2'd1;
                end else if (sel_value[31:16] == 16'd0) begin
                    size_code = 2'd2;
                end else begin
                    size_code = 2'd3;
                end
            end
            default: size_code = 2'd3;
        endcase
        nbytes = (size_code == 2'd3) ? 3'd4 : {1'b0, size_code};

        later_mask = change_reg & ~((STEP_COUNT'(2) << step_reg) - STEP_COUNT'(1));

        state_next    = state_reg;
        step_next     = step_reg;
        byte_next     = byte_reg;
        change_next   = change_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tlast_next  = m_tlast_reg;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_xfer && (s_tuser == FUNC_EMIT) && (in_change != '0)) begin
                    state_next  = ST_RUN;
                    step_next   = '0;
                    byte_next   = '0;
                    change_next = in_change;
                end
            end
            ST_RUN: begin
                if (!change_reg[step_reg]) begin
                    step_next = step_reg + STEP_W'(1);
                    if (ctrl.end_step) begin
                        state_next = ST_IDLE;
                    end
                end else if (out_free) begin
                    m_tvalid_next = 1'b1;
                    case (byte_reg)
                        3'd0:    m_tdata_next = (ctrl.tag & TAG_MASK) | {6'd0, size_code};
                        3'd1:    m_tdata_next = sel_value[7:0];
                        3'd2:    m_tdata_next = sel_value[15:8];
                        3'd3:    m_tdata_next = sel_value[23:16];
                        default: m_tdata_next = sel_value[31:24];
                    endcase
                    if (byte_reg == nbytes) begin
                        m_tlast_next = (later_mask == '0);
                        byte_next    = '0;
                        step_next    = step_reg + STEP_W'(1);
                        if (ctrl.end_step || (later_mask == '0)) begin
                            state_next = ST_IDLE;
                        end
                    end else begin
                        m_tlast_next = 1'b0;
                        byte_next    = byte_reg + 3'd1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for hid_global_item_delta_encoder: drives sets of HID global
// values and compares each output byte with a predictor of the delta item encoding.
// Depends on hgide_pkg and the encoder RTL only.
`timescale 1ns / 1ps

module tb_top;
    import hgide_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int SETTLE_TICKS = 48;

    // Packed so that report_id lands in the lowest bits of s_tdata.
    typedef struct packed {
        logic [15:0] field_count;
        logic [15:0] field_size;
        logic [31:0] unit_code;
        logic [31:0] unit_exponent;
        logic [31:0] physical_max;
        logic [31:0] physical_min;
        logic [31:0] logical_max;
        logic [31:0] logical_min;
        logic [15:0] usage_page;
        logic [7:0]  report_id;
    } hid_globals_t;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    // report_id, usage_page, logical_min, logical_max, physical_min, physical_max,
    // unit_exponent, unit_code, field_size, field_count
    logic [247:0] s_tdata  = '0;
    // func
    logic         s_tuser  = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // out_byte
    logic [7:0]   m_tdata;
    logic         m_tlast;

    logic [8:0]   expected_bytes[$];
    hid_globals_t last_sent;
    bit           idle_on;
    int           mismatches;
    int           cycles;
    int           stall_left;

    hid_global_item_delta_encoder u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    function automatic int signed_len(input logic [31:0] v);
        if (v == 32'd0) return 0;
        if ($signed(v) >= -128 && $signed(v) <= 127) return 1;
        if ($signed(v) >= -32768 && $signed(v) <= 32767) return 2;
        return 4;
    endfunction

    function automatic int unsigned_len(input logic [31:0] v);
        if (v == 32'd0) return 0;
        if (v <= 32'h0000_00FF) return 1;
        if (v <= 32'h0000_FFFF) return 2;
        return 4;
    endfunction

    task automatic push_item(input logic [7:0] tag, input logic [31:0] value, input int len);
        logic [1:0] size_code;
        size_code = (len == 4) ? 2'd3 : 2'(len);
        expected_bytes.insert(expected_bytes.size(),
                              {1'b0, (tag & TAG_MASK) | {6'd0, size_code}});
        for (int k = 0; k < len; k++)
            expected_bytes.insert(expected_bytes.size(), {1'b0, value[8*k +: 8]});
    endtask

    task automatic predict_descriptor_bytes(input logic func, input hid_globals_t g);
        int first;
        first = expected_bytes.size();
        if (func == FUNC_SET_PAGE) begin
            last_sent.usage_page = g.usage_page;
            return;
        end
        if (g.report_id != last_sent.report_id)
            push_item(TAG_REPORT_ID, {24'd0, g.report_id}, 1);
        if (g.usage_page != last_sent.usage_page)
            push_item(TAG_USAGE_PAGE, {16'd0, g.usage_page}, (g.usage_page > 16'h00FF) ? 2 : 1);
        if (g.logical_min != last_sent.logical_min)
            push_item(TAG_LOG_MIN, g.logical_min, signed_len(g.logical_min));
        if (g.logical_max != last_sent.logical_max)
            push_item(TAG_LOG_MAX, g.logical_max, signed_len(g.logical_max));
        if (g.physical_min != last_sent.physical_min)
            push_item(TAG_PHY_MIN, g.physical_min, signed_len(g.physical_min));
        if (g.physical_max != last_sent.physical_max)
            push_item(TAG_PHY_MAX, g.physical_max, signed_len(g.physical_max));
        if (g.unit_exponent != last_sent.unit_exponent)
            push_item(TAG_UNIT_EXP, g.unit_exponent, unsigned_len(g.unit_exponent));
        if (g.unit_code != last_sent.unit_code)
            push_item(TAG_UNIT, g.unit_code, unsigned_len(g.unit_code));
        if (g.field_size != last_sent.field_size)
            push_item(TAG_REPORT_SIZE, {16'd0, g.field_size}, unsigned_len({16'd0, g.field_size}));
        if (g.field_count != last_sent.field_count)
            push_item(TAG_REPORT_COUNT, {16'd0, g.field_count},
                      unsigned_len({16'd0, g.field_count}));
        last_sent = g;
        if (expected_bytes.size() > first)
            expected_bytes[expected_bytes.size() - 1] = expected_bytes[expected_bytes.size() - 1]
                                                        | 9'h100;
    endtask

    // Receiver: checks each output transfer and draws a stall after it while idle_on is set.
    always @(posedge aclk) begin
        logic [8:0] want;
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_bytes.size() == 0) begin
                    report_mismatch($sformatf("unexpected byte %02h last %0b", m_tdata, m_tlast));
                end else begin
                    want = expected_bytes.pop_front();
                    if (m_tdata !== want[7:0])
                        report_mismatch($sformatf("byte %02h, expected %02h", m_tdata, want[7:0]));
                    if (m_tlast !== want[8])
                        report_mismatch($sformatf("last %0b, expected %0b on byte %02h",
                                                  m_tlast, want[8], want[7:0]));
                end
                stall_left = idle_on ? $urandom_range(0, 3) : 0;
            end else if (stall_left > 0) begin
                stall_left--;
            end
            m_tready <= (stall_left == 0);
        end
    end

    task automatic send_globals(input logic func, input hid_globals_t g);
        int gap;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= g;
        s_tuser  <= func;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_descriptor_bytes(func, g);
    endtask

    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        while (expected_bytes.size() != 0) @(posedge aclk);
        repeat (SETTLE_TICKS) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_value(input bit as_signed);
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 6))
            0: return 32'd0;
            1: return as_signed ? {{24{r[7]}}, r[7:0]} : {24'd0, r[7:0]};
            2: return as_signed ? {{23{r[8]}}, r[8:0]} : {23'd0, r[8:0]};
            3: return as_signed ? {{16{r[15]}}, r[15:0]} : {16'd0, r[15:0]};
            4: return as_signed ? {{15{r[16]}}, r[16:0]} : {15'd0, r[16:0]};
            default: return r;
        endcase
    endfunction

    function automatic hid_globals_t random_globals();
        hid_globals_t g;
        logic [31:0]  v;
        g.report_id = ($urandom_range(0, 7) == 0) ? NO_ID_YET : 8'($urandom_range(0, 255));
        v = pick_value(1'b0);
        g.usage_page    = v[15:0];
        g.logical_min   = pick_value(1'b1);
        g.logical_max   = pick_value(1'b1);
        g.physical_min  = pick_value(1'b1);
        g.physical_max  = pick_value(1'b1);
        g.unit_exponent = pick_value(1'b0);
        g.unit_code     = pick_value(1'b0);
        v = pick_value(1'b0);
        g.field_size    = v[15:0];
        v = pick_value(1'b0);
        g.field_count   = v[15:0];
        return g;
    endfunction

    task automatic test_reset_state();
        hid_globals_t g;
        g = '0;
        g.report_id = NO_ID_YET;
        send_globals(FUNC_EMIT, g);
        send_globals(FUNC_EMIT, g);
        wait_for_drain();
    endtask

    task automatic test_field_extremes();
        logic [31:0]  signed_edges[13] = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
            32'h0000_007F, 32'h0000_0080, 32'hFFFF_FF80, 32'hFFFF_FF7F, 32'h0000_7FFF,
            32'h0000_8000, 32'hFFFF_8000, 32'hFFFF_7FFF, 32'h7FFF_FFFF, 32'h8000_0000};
        logic [31:0]  unsigned_edges[13] = '{32'h0000_0000, 32'h0000_0001, 32'h0000_00FF,
            32'h0000_0100, 32'h0000_FFFF, 32'h0001_0000, 32'hFFFF_FFFF, 32'h0000_0080,
            32'h0000_8000, 32'h0000_007F, 32'h0000_7FFF, 32'h8000_0000, 32'h00FF_FFFF};
        logic [15:0]  pages[5] = '{16'h0001, 16'h00FF, 16'h0100, 16'hFFFF, 16'h0000};
        hid_globals_t g;
        logic [31:0]  v;
        for (int i = 0; i < 13; i++) begin
            g.report_id     = (i % 2 == 0) ? 8'h00 : NO_ID_YET;
            g.usage_page    = pages[i % 5];
            g.logical_min   = signed_edges[i];
            g.logical_max   = signed_edges[(i + 3) % 13];
            g.physical_min  = signed_edges[(i + 6) % 13];
            g.physical_max  = signed_edges[(i + 9) % 13];
            g.unit_exponent = unsigned_edges[i];
            g.unit_code     = unsigned_edges[(i + 5) % 13];
            v = unsigned_edges[(i + 2) % 13];
            g.field_size    = v[15:0];
            v = unsigned_edges[(i + 8) % 13];
            g.field_count   = v[15:0];
            send_globals(FUNC_EMIT, g);
        end
        wait_for_drain();
    endtask

    task automatic test_usage_page_overwrite();
        hid_globals_t g;
        g = random_globals();
        g.usage_page = 16'hABCD;
        send_globals(FUNC_SET_PAGE, g);
        g = last_sent;
        g.usage_page = 16'hABCD;
        send_globals(FUNC_EMIT, g);
        send_globals(FUNC_SET_PAGE, random_globals());
        g.field_count = ~g.field_count;
        send_globals(FUNC_EMIT, g);
        wait_for_drain();
    endtask

    task automatic test_unchanged_set();
        hid_globals_t g;
        g = random_globals();
        send_globals(FUNC_EMIT, g);
        send_globals(FUNC_EMIT, g);
        send_globals(FUNC_EMIT, g);
        wait_for_drain();
    endtask

    task automatic test_random_deltas(input int count);
        hid_globals_t cur;
        hid_globals_t next;
        hid_globals_t g;
        int           roll;
        logic [9:0]   change;
        cur = last_sent;
        for (int n = 0; n < count; n++) begin
            idle_on = ((n / 30) % 3) != 2;
            if (n % 70 == 69) wait_for_drain();
            roll = $urandom_range(0, 9);
            next = random_globals();
            if (roll == 0) begin
                send_globals(FUNC_SET_PAGE, next);
                cur.usage_page = next.usage_page;
            end else begin
                if (roll == 1) change = '1;
                else if (roll == 2) change = '0;
                else change = 10'($urandom) & 10'($urandom);
                g = cur;
                if (change[0]) g.report_id     = next.report_id;
                if (change[1]) g.usage_page    = next.usage_page;
                if (change[2]) g.logical_min   = next.logical_min;
                if (change[3]) g.logical_max   = next.logical_max;
                if (change[4]) g.physical_min  = next.physical_min;
                if (change[5]) g.physical_max  = next.physical_max;
                if (change[6]) g.unit_exponent = next.unit_exponent;
                if (change[7]) g.unit_code     = next.unit_code;
                if (change[8]) g.field_size    = next.field_size;
                if (change[9]) g.field_count   = next.field_count;
                send_globals(FUNC_EMIT, g);
                cur = g;
            end
        end
        wait_for_drain();
    endtask

    initial begin
        last_sent           = '0;
        last_sent.report_id = NO_ID_YET;
        idle_on             = 1'b1;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_state();
        test_field_extremes();
        test_usage_page_overwrite();
        test_unchanged_set();
        test_random_deltas(188);

        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
